FILE: src/hxfp_pkg.sv
`default_nettype none
package hxfp_pkg;

    localparam int BYTE_W     = 8;
    localparam int VEL_W      = 16;
    localparam int DIS_W      = 32;
    localparam int OUT_W      = 30;
    localparam int VCNT_W     = 3;
    localparam int DCNT_W     = 4;

    localparam logic [BYTE_W-1:0] LF_BYTE   = 8'h0A;
    localparam logic [BYTE_W-1:0] IDLE_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] CHAR_V    = 8'h56;
    localparam logic [BYTE_W-1:0] CHAR_D    = 8'h44;

    localparam logic [VCNT_W-1:0] VEL_DIGITS = 3'd4;
    localparam logic [DCNT_W-1:0] DIS_DIGITS = 4'd8;

    localparam logic KIND_VELOCITY = 1'b0;
    localparam logic KIND_DISTANCE = 1'b1;

    // '0'-'9' and 'A'-'F' map to 0..15, anything else passes through raw
    function automatic logic [BYTE_W-1:0] digit_value(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] d;
        if (b >= 8'd48 && b <= 8'd57)
        begin
            d = b - 8'd48;
        end
        else if (b >= 8'd65 && b <= 8'd70)
        begin
            d = b - 8'd55;
        end
        else
        begin
            d = b;
        end
        return d;
    endfunction

    // signed divide by 4, truncated toward zero: bias negatives by 3, then shift
    function automatic logic [OUT_W-1:0] quarter_vel(input logic [VEL_W-1:0] v);
        logic signed [VEL_W:0] ext;
        logic signed [VEL_W:0] q;
        ext = $signed({v[VEL_W-1], v});
        if (v[VEL_W-1])
        begin
            ext = ext + 17'sd3;
        end
        q = ext >>> 2;
        return {{(OUT_W-VEL_W-1){q[VEL_W]}}, q};
    endfunction

    function automatic logic [OUT_W-1:0] quarter_dis(input logic [DIS_W-1:0] v);
        logic signed [DIS_W:0] ext;
        logic signed [DIS_W:0] q;
        ext = $signed({v[DIS_W-1], v});
        if (v[DIS_W-1])
        begin
            ext = ext + 33'sd3;
        end
        q = ext >>> 2;
        return q[OUT_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: src/hex_ascii_encoder_frame_parser_top.sv
// The completing digit passes through the input register, then the result register.
// Throughput: one byte per cycle; the input register feeds the state update
// and the result register in a single pass, stalling only on output backpressure.
// Reset: asynchronous, active low; clears the marker, both fields, counts and
// accumulators, and empties both pipeline registers.
`default_nettype none
module hex_ascii_encoder_frame_parser_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             value_kind,
    output logic [29:0]      measured_value
);

    logic                                s1_valid_reg;
    logic [hxfp_pkg::BYTE_W-1:0]         s1_byte_reg;

    logic                                lf_seen_reg,  lf_seen_next;
    logic                                vel_open_reg, vel_open_next;
    logic                                dis_open_reg, dis_open_next;
    logic [hxfp_pkg::VCNT_W-1:0]         vel_cnt_reg,  vel_cnt_next;
    logic [hxfp_pkg::DCNT_W-1:0]         dis_cnt_reg,  dis_cnt_next;
    logic [hxfp_pkg::VEL_W-1:0]          vel_acc_reg,  vel_acc_next;
    logic [hxfp_pkg::DIS_W-1:0]          dis_acc_reg,  dis_acc_next;

    logic                                out_valid_reg;
    logic                                kind_reg,  kind_next;
    logic [hxfp_pkg::OUT_W-1:0]          value_reg, value_next;
    logic                                emit;

    logic                                advance;
    logic [hxfp_pkg::BYTE_W-1:0]         dv;
    logic [hxfp_pkg::VCNT_W-1:0]         vel_cnt_inc;
    logic [hxfp_pkg::DCNT_W-1:0]         dis_cnt_inc;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;

    assign out_valid      = out_valid_reg;
    assign value_kind     = kind_reg;
    assign measured_value = value_reg;

    assign dv          = hxfp_pkg::digit_value(s1_byte_reg);
    assign vel_cnt_inc = vel_cnt_reg + 1'b1;
    assign dis_cnt_inc = dis_cnt_reg + 1'b1;

    always_comb
    begin
        lf_seen_next  = lf_seen_reg;
        vel_open_next = vel_open_reg;
        dis_open_next = dis_open_reg;
        vel_cnt_next  = vel_cnt_reg;
        dis_cnt_next  = dis_cnt_reg;
        vel_acc_next  = vel_acc_reg;
        dis_acc_next  = dis_acc_reg;
        emit          = 1'b0;
        kind_next     = kind_reg;
        value_next    = value_reg;

        priority if (s1_byte_reg == hxfp_pkg::IDLE_BYTE)
        begin
            // idle filler, nothing to do
        end
        else if (s1_byte_reg == hxfp_pkg::LF_BYTE)
        begin
            lf_seen_next = 1'b1;
        end
        else if (lf_seen_reg && s1_byte_reg == hxfp_pkg::CHAR_V)
        begin
            vel_open_next = 1'b1;
            vel_cnt_next  = '0;
            vel_acc_next  = '0;
            lf_seen_next  = 1'b0;
        end
        else if (lf_seen_reg && s1_byte_reg == hxfp_pkg::CHAR_D)
        begin
            dis_open_next = 1'b1;
            dis_cnt_next  = '0;
            dis_acc_next  = '0;
            lf_seen_next  = 1'b0;
        end
        else if (vel_open_reg)
        begin
            // raw non-hex bytes spill their high nibble into the previous digit
            vel_acc_next = {vel_acc_reg[hxfp_pkg::VEL_W-5:0], 4'h0}
                         | {{(hxfp_pkg::VEL_W-hxfp_pkg::BYTE_W){1'b0}}, dv};
            vel_cnt_next = vel_cnt_inc;
            if (vel_cnt_inc >= hxfp_pkg::VEL_DIGITS)
            begin
                vel_open_next = 1'b0;
                vel_cnt_next  = '0;
                emit          = 1'b1;
                kind_next     = hxfp_pkg::KIND_VELOCITY;
                value_next    = hxfp_pkg::quarter_vel(vel_acc_next);
            end
        end
        else if (dis_open_reg)
        begin
            dis_acc_next = {dis_acc_reg[hxfp_pkg::DIS_W-5:0], 4'h0}
                         | {{(hxfp_pkg::DIS_W-hxfp_pkg::BYTE_W){1'b0}}, dv};
            dis_cnt_next = dis_cnt_inc;
            if (dis_cnt_inc >= hxfp_pkg::DIS_DIGITS)
            begin
                dis_open_next = 1'b0;
                dis_cnt_next  = '0;
                emit          = 1'b1;
                kind_next     = hxfp_pkg::KIND_DISTANCE;
                value_next    = hxfp_pkg::quarter_dis(dis_acc_next);
            end
        end
        else
        begin
            // stray byte with no field open
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            lf_seen_reg   <= 1'b0;
            vel_open_reg  <= 1'b0;
            dis_open_reg  <= 1'b0;
            vel_cnt_reg   <= '0;
            dis_cnt_reg   <= '0;
            vel_acc_reg   <= '0;
            dis_acc_reg   <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg && emit;
            end
            if (advance && s1_valid_reg)
            begin
                lf_seen_reg  <= lf_seen_next;
                vel_open_reg <= vel_open_next;
                dis_open_reg <= dis_open_next;
                vel_cnt_reg  <= vel_cnt_next;
                dis_cnt_reg  <= dis_cnt_next;
                vel_acc_reg  <= vel_acc_next;
                dis_acc_reg  <= dis_acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= rx_byte;
        end
        if (advance && s1_valid_reg && emit)
        begin
            kind_reg  <= kind_next;
            value_reg <= value_next;
        end
    end

endmodule
`default_nettype wire

FILE: src/hxfp_checker.sv
`default_nettype none
module hxfp_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [7:0]  rx_byte,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        value_kind,
    input wire logic [29:0] measured_value
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value_kind)
                                    && $stable(measured_value))
        else $error("stalled result changed");

    // every new result comes from an earlier input transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a source transaction");

    // idle bytes and line feeds never complete a field
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready
        && (rx_byte == hxfp_pkg::IDLE_BYTE || rx_byte == hxfp_pkg::LF_BYTE)
        |=> ##1 !$rose(out_valid))
        else $error("result from idle byte or line feed");

    // a velocity is a 16-bit value over four, so it fits in 14 signed bits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && value_kind == hxfp_pkg::KIND_VELOCITY
        |-> measured_value[29:13] == 17'h00000 || measured_value[29:13] == 17'h1FFFF)
        else $error("velocity out of range");

endmodule

bind hex_ascii_encoder_frame_parser_top hxfp_checker u_hxfp_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .value_kind     (value_kind),
    .measured_value (measured_value)
);
`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import hxfp_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT  = 2000;

    typedef struct packed
    {
        logic        kind;
        logic [29:0] value;
    } reading_t;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte        = 8'h00;
    logic        out_valid;
    logic        out_ready      = 1'b0;
    logic        value_kind;
    logic [29:0] measured_value;

    int send_idle_pct = 0;
    int rcv_idle_pct  = 0;
    int error_count   = 0;
    int stall_cycles  = 0;

    // parser state as predicted
    logic        lf_armed;
    logic        vel_open;
    logic        dis_open;
    logic [2:0]  vel_cnt;
    logic [3:0]  dis_cnt;
    logic [15:0] vel_acc;
    logic [31:0] dis_acc;

    reading_t expected_readings[$];

    hex_ascii_encoder_frame_parser_top i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .value_kind     (value_kind),
        .measured_value (measured_value)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    function automatic logic [7:0] nibble_of(input logic [7:0] c);
        logic [7:0] n;
        if (c >= "0" && c <= "9")
        begin
            n = c - "0";
        end
        else if (c >= "A" && c <= "F")
        begin
            n = c - "A" + 8'd10;
        end
        else
        begin
            n = c;
        end
        return n;
    endfunction

    // signed integer division already truncates toward zero
    function automatic logic [29:0] quarter_of(input int whole);
        int q;
        q = whole / 4;
        return q[29:0];
    endfunction

    function automatic void predict_byte(input logic [7:0] b);
        logic [7:0] d;
        d = nibble_of(b);
        if (b == IDLE_BYTE)
        begin
            return;
        end
        if (b == LF_BYTE)
        begin
            lf_armed = 1'b1;
        end
        else if (lf_armed && b == CHAR_V)
        begin
            vel_open = 1'b1;
            vel_cnt  = '0;
            vel_acc  = '0;
            lf_armed = 1'b0;
        end
        else if (lf_armed && b == CHAR_D)
        begin
            dis_open = 1'b1;
            dis_cnt  = '0;
            dis_acc  = '0;
            lf_armed = 1'b0;
        end
        else if (vel_open)
        begin
            // raw non-hex bytes spill their upper bits into the previous nibble
            vel_acc = (vel_acc << 4) | 16'(d);
            vel_cnt = vel_cnt + 1'b1;
            if (vel_cnt >= VEL_DIGITS)
            begin
                vel_open = 1'b0;
                vel_cnt  = '0;
                expected_readings.push_back('{kind: KIND_VELOCITY,
                                              value: quarter_of(int'($signed(vel_acc)))});
            end
        end
        else if (dis_open)
        begin
            dis_acc = (dis_acc << 4) | 32'(d);
            dis_cnt = dis_cnt + 1'b1;
            if (dis_cnt >= DIS_DIGITS)
            begin
                dis_open = 1'b0;
                dis_cnt  = '0;
                expected_readings.push_back('{kind: KIND_DISTANCE,
                                              value: quarter_of(int'($signed(dis_acc)))});
            end
        end
    endfunction

    // predict on input transactions, check on output transactions
    always @(posedge clk)
    begin : monitor
        reading_t want;
        if (rst_n && in_valid && in_ready)
        begin
            predict_byte(rx_byte);
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_readings.size() == 0)
            begin
                $display("%0t: unexpected reading, actual kind %0d value %0d",
                         $time, value_kind, $signed(measured_value));
                error_count++;
            end
            else
            begin
                want = expected_readings.pop_front();
                if (value_kind !== want.kind)
                begin
                    $display("%0t: value_kind expected %0d actual %0d",
                             $time, want.kind, value_kind);
                    error_count++;
                end
                if (measured_value !== want.value)
                begin
                    $display("%0t: measured_value expected %0d actual %0d",
                             $time, $signed(want.value), $signed(measured_value));
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic wait_readings_drained();
        in_valid <= 1'b0;
        while (expected_readings.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] random_hex_char();
        int corners[4] = '{0, 7, 8, 15};
        int n;
        n = ($urandom_range(2) == 0) ? corners[$urandom_range(3)] : $urandom_range(15);
        return (n < 10) ? 8'(48 + n) : 8'(55 + n);
    endfunction

    // mostly well-formed frames with random digits, plus noise and broken frames
    task automatic run_frame_traffic(input int n_items);
        int          sent;
        int          digits;
        logic        is_vel;
        logic [7:0]  b;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 20)
            begin
                b = 8'($urandom_range(255));
                send_byte(b);
                if (b != IDLE_BYTE)
                begin
                    sent++;
                end
            end
            else
            begin
                is_vel = 1'($urandom_range(1));
                send_byte(LF_BYTE);
                send_byte(is_vel ? CHAR_V : CHAR_D);
                sent += 2;
                digits = is_vel ? 4 : 8;
                if ($urandom_range(9) == 0)
                begin
                    digits = $urandom_range(digits - 1);
                end
                for (int k = 0; k < digits; k++)
                begin
                    if ($urandom_range(19) == 0)
                    begin
                        send_byte(IDLE_BYTE);
                    end
                    case ($urandom_range(49))
                        0:       b = LF_BYTE;
                        1:       b = ($urandom_range(1) != 0) ? CHAR_V : CHAR_D;
                        2, 3, 4: b = 8'($urandom_range(255));
                        default: b = random_hex_char();
                    endcase
                    send_byte(b);
                    if (b != IDLE_BYTE)
                    begin
                        sent++;
                    end
                end
            end
        end
    endtask

    // idle byte, armed marker inside a field, overlapping fields,
    // raw non-hex digits, unarmed V and D taken as digits
    task automatic test_special_cases();
        logic [7:0] seq[] = '{8'h00, LF_BYTE, CHAR_V, "8", IDLE_BYTE, "0", LF_BYTE, "0", "0",
                              CHAR_D, "F", "F", LF_BYTE, CHAR_V, "z", CHAR_V, "f", "1",
                              "F", "F", "F", "F", "F", CHAR_D};
        send_idle_pct = 7;
        rcv_idle_pct  = 77;
        foreach (seq[i])
        begin
            send_byte(seq[i]);
        end
        wait_readings_drained();
    endtask

    task automatic test_receiver_backpressure();
        send_idle_pct = 7;
        rcv_idle_pct  = 77;
        run_frame_traffic(550);
        wait_readings_drained();
    endtask

    task automatic test_sender_gaps();
        send_idle_pct = 77;
        rcv_idle_pct  = 7;
        run_frame_traffic(550);
        wait_readings_drained();
    endtask

    task automatic test_full_rate();
        send_idle_pct = 0;
        rcv_idle_pct  = 0;
        run_frame_traffic(550);
        wait_readings_drained();
    endtask

    initial
    begin
        lf_armed = 1'b0;
        vel_open = 1'b0;
        dis_open = 1'b0;
        vel_cnt  = '0;
        dis_cnt  = '0;
        vel_acc  = '0;
        dis_acc  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_cases();
        test_receiver_backpressure();
        test_sender_gaps();
        test_full_rate();

        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
